FILE: design/e2c_pkg.sv
// ----------------------------------------------------------------------------
// e2c_pkg: shared types and constants for the epoch to calendar converter
// Word widths, conversion constants, the sequencer's state type and the
// month length lookup used by the datapath.
// ----------------------------------------------------------------------------
package e2c_pkg;

	// Width of the working word: the whole input count of seconds fits.
	localparam int WORD_W = 31;
	typedef logic [WORD_W-1:0] word_t;

	// Step counter, wide enough for the longest restoring division.
	typedef logic [3:0] step_t;

	// Time constants in seconds.
	localparam word_t SECS_PER_MIN  = word_t'(60);
	localparam word_t SECS_PER_HOUR = word_t'(60 * 60);
	localparam word_t SECS_PER_DAY  = word_t'(24 * 60 * 60);
	localparam word_t DAYS_PER_WEEK = word_t'(7);

	// Quotient bits produced by each restoring division.
	localparam int DAY_QBITS  = 15;
	localparam int HOUR_QBITS = 5;
	localparam int MIN_QBITS  = 6;
	localparam int WDAY_QBITS = 12;

	// Calendar constants.
	localparam logic [6:0] EPOCH_YY      = 7'd70;
	localparam logic [6:0] LAST_YY       = 7'd99;
	localparam logic [3:0] LAST_MONTH    = 4'd11;
	localparam logic [3:0] FEBRUARY      = 4'd1;
	localparam logic [2:0] EPOCH_WEEKDAY = 3'd4;
	localparam logic [8:0] DAYS_NORMAL   = 9'd365;
	localparam logic [8:0] DAYS_LEAP     = 9'd366;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DAYS,
		ST_HOUR,
		ST_MIN,
		ST_YEAR,
		ST_MONTH,
		ST_WDAY,
		ST_DONE
	} state_t;

	// Days in a month; February gains one day in a leap year.
	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] d;
		begin
			case (month)
				4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: d = 5'd31;
				4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
				FEBRUARY: d = leap ? 5'd29 : 5'd28;
				default: d = 5'd31;
			endcase
			return d;
		end
	endfunction

endpackage

FILE: design/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970 to broken-down calendar time
// Sequencer around one shared compare and subtract unit.
// ----------------------------------------------------------------------------
// One word in gives one word out. Every step of the conversion goes through a
// single compare and subtract unit, one step per cycle: a 15 step restoring
// division of the seconds by the day length, 5 and 6 step divisions for hour
// and minute, one step per year walked forward from 1970, one step per month
// walked through the year, and a 12 step division by seven for the weekday.
// The input range ends in January 2038. The input is stalled while a word is
// converted; the finished word sits in an output register, so a new word is
// taken while the previous result is still waiting.
module epoch_seconds_to_calendar (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [30:0] epoch_seconds,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [5:0] second,
	output logic [5:0] minute,
	output logic [4:0] hour,
	output logic [6:0] year_two_digit,
	output logic [8:0] day_of_year,
	output logic [3:0] month_index,
	output logic [4:0] day_of_month,
	output logic [2:0] weekday
);
	import e2c_pkg::*;

	state_t state_q, state_d;

	// Working registers.
	word_t       acc_q;
	logic [14:0] quo_q;
	step_t       step_q;
	logic [14:0] days_q;
	logic [6:0]  yy_q;
	logic [3:0]  month_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [8:0]  yday_q;
	logic [4:0]  mday_q;
	logic [2:0]  wday_q;

	// Output register.
	logic        out_valid_q;
	logic [5:0]  second_q;
	logic [5:0]  minute_q;
	logic [4:0]  hour_out_q;
	logic [6:0]  yy_out_q;
	logic [8:0]  yday_out_q;
	logic [3:0]  month_out_q;
	logic [4:0]  mday_out_q;
	logic [2:0]  wday_out_q;

	// Shared unit and its operands.
	word_t       sub_val;
	logic        ge;
	word_t       diff;
	word_t       acc_next;
	logic [14:0] quo_next;
	logic        leap;
	logic        month_take;
	logic        load_out;
	logic        accept;

	e2c_csub u_csub (
		.minuend   (acc_q),
		.subtrahend(sub_val),
		.ge        (ge),
		.diff      (diff)
	);

	// Within 1970..2038 the only century year is 2000, which is leap,
	// so the low two bits of the two digit year decide.
	assign leap       = (yy_q[1:0] == 2'b00);
	assign month_take = (month_q < LAST_MONTH) && ge;
	assign acc_next   = ge ? diff : acc_q;
	assign quo_next   = {quo_q[13:0], ge};
	assign accept     = in_valid && !in_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_DAYS;
			ST_DAYS:  if (step_q == '0) state_d = ST_HOUR;
			ST_HOUR:  if (step_q == '0) state_d = ST_MIN;
			ST_MIN:   if (step_q == '0) state_d = ST_YEAR;
			ST_YEAR:  if (!ge) state_d = ST_MONTH;
			ST_MONTH: if (!month_take) state_d = ST_WDAY;
			ST_WDAY:  if (step_q == '0) state_d = ST_DONE;
			ST_DONE:  if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control outputs: subtrahend selection and handshakes.
	always_comb begin
		sub_val  = '0;
		in_stall = 1'b1;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:  in_stall = 1'b0;
			ST_DAYS:  sub_val = SECS_PER_DAY << step_q;
			ST_HOUR:  sub_val = SECS_PER_HOUR << step_q;
			ST_MIN:   sub_val = SECS_PER_MIN << step_q;
			ST_YEAR:  sub_val = word_t'(leap ? DAYS_LEAP : DAYS_NORMAL);
			ST_MONTH: sub_val = word_t'(month_days(month_q, leap));
			ST_WDAY:  sub_val = DAYS_PER_WEEK << step_q;
			ST_DONE:  load_out = !out_valid_q || !out_stall;
			default:  sub_val = '0;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, stepped by the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					acc_q  <= word_t'(epoch_seconds);
					quo_q  <= '0;
					step_q <= step_t'(DAY_QBITS - 1);
				end
			end
			ST_DAYS: begin
				acc_q <= acc_next;
				if (step_q == '0) begin
					days_q <= quo_next;
					quo_q  <= '0;
					step_q <= step_t'(HOUR_QBITS - 1);
				end else begin
					quo_q  <= quo_next;
					step_q <= step_q - step_t'(1);
				end
			end
			ST_HOUR: begin
				acc_q <= acc_next;
				if (step_q == '0) begin
					hour_q <= quo_next[HOUR_QBITS-1:0];
					quo_q  <= '0;
					step_q <= step_t'(MIN_QBITS - 1);
				end else begin
					quo_q  <= quo_next;
					step_q <= step_q - step_t'(1);
				end
			end
			ST_MIN: begin
				if (step_q == '0) begin
					min_q <= quo_next[MIN_QBITS-1:0];
					sec_q <= acc_next[5:0];
					acc_q <= word_t'(days_q);
					yy_q  <= EPOCH_YY;
				end else begin
					acc_q  <= acc_next;
					quo_q  <= quo_next;
					step_q <= step_q - step_t'(1);
				end
			end
			ST_YEAR: begin
				// Walk forward a whole year while the remaining days allow it.
				if (ge) begin
					acc_q <= diff;
					yy_q  <= (yy_q == LAST_YY) ? 7'd0 : yy_q + 7'd1;
				end else begin
					yday_q  <= acc_q[8:0];
					month_q <= '0;
				end
			end
			ST_MONTH: begin
				if (month_take) begin
					acc_q   <= diff;
					month_q <= month_q + 4'd1;
				end else begin
					mday_q <= acc_q[4:0] + 5'd1;
					acc_q  <= word_t'(days_q) + word_t'(EPOCH_WEEKDAY);
					quo_q  <= '0;
					step_q <= step_t'(WDAY_QBITS - 1);
				end
			end
			ST_WDAY: begin
				acc_q <= acc_next;
				quo_q <= quo_next;
				if (step_q == '0) begin
					wday_q <= acc_next[2:0];
				end else begin
					step_q <= step_q - step_t'(1);
				end
			end
			ST_DONE: begin
				if (load_out) begin
					second_q    <= sec_q;
					minute_q    <= min_q;
					hour_out_q  <= hour_q;
					yy_out_q    <= yy_q;
					yday_out_q  <= yday_q;
					month_out_q <= month_q;
					mday_out_q  <= mday_q;
					wday_out_q  <= wday_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign second         = second_q;
	assign minute         = minute_q;
	assign hour           = hour_out_q;
	assign year_two_digit = yy_out_q;
	assign day_of_year    = yday_out_q;
	assign month_index    = month_out_q;
	assign day_of_month   = mday_out_q;
	assign weekday        = wday_out_q;

	// Time of day fields of a delivered word are in range.
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60))
		else $error("time of day out of range");

	// Date fields of a delivered word are in range.
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month_index <= LAST_MONTH) && (day_of_month != 5'd0)
			&& (weekday < 3'd7) && (year_two_digit <= LAST_YY))
		else $error("calendar date out of range");

	// An accepted word starts the day division on the next cycle.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_DAYS))
		else $error("accepted word did not start conversion");

	// The year walk only ever holds a day count.
	a_year_days: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_YEAR) |-> (acc_q[WORD_W-1:DAY_QBITS] == '0))
		else $error("day count overflow during year walk");

endmodule

FILE: design/e2c_csub.sv
// ----------------------------------------------------------------------------
// e2c_csub: shared compare and subtract unit
// Compares the working word against a subtrahend and gives the difference,
// so the sequencer can take it conditionally.
// ----------------------------------------------------------------------------
module e2c_csub (
	input  e2c_pkg::word_t minuend,
	input  e2c_pkg::word_t subtrahend,
	output logic           ge,
	output e2c_pkg::word_t diff
);
	import e2c_pkg::*;

	logic [WORD_W:0] wide_diff;

	// One subtraction with a borrow bit serves both compare and difference.
	assign wide_diff = {1'b0, minuend} - {1'b0, subtrahend};
	assign ge        = ~wide_diff[WORD_W];
	assign diff      = wide_diff[WORD_W-1:0];

endmodule
